[src/ddwm_pkg.sv]
package ddwm_pkg;

  localparam int SPD_W   = 16;               // linear_speed, turn_rate
  localparam int HTW_W   = 16;
  localparam int RPS_W   = 16;
  localparam int MWS_W   = 14;
  localparam int TRIM_W  = 16;
  localparam int CFG_W   = 16;               // widest register
  localparam int DELTA_W = 32;               // turn * half track
  localparam int TRACK_W = 33;               // track speed, Q.28
  localparam int PROD_W  = 49;               // track speed * rpm_per_speed
  localparam int WHEEL_W = 32;               // wheel speed, 1/64 rpm with 8 fraction bits
  localparam int MAG_W   = 31;               // wheel speed magnitude
  localparam int TPROD_W = 48;               // wheel speed * trim gain
  localparam int QUO_W   = 14;               // scaled magnitude, never above the limit
  localparam int NUM_W   = MAG_W + MWS_W;    // scaling dividend
  localparam int CNT_W   = $clog2(QUO_W);
  localparam int RND_W   = MAG_W + 1 - 8;    // unscaled magnitude after rounding
  localparam int OUT_W   = 15;
  localparam int TDATA_IN_W  = 32;
  localparam int TDATA_OUT_W = 32;

  localparam logic [QUO_W-1:0] OUT_LIMIT = QUO_W'(16000);

  localparam logic [HTW_W-1:0]  HTW_RST  = HTW_W'(8323);
  localparam logic [RPS_W-1:0]  RPS_RST  = RPS_W'(7025);
  localparam logic [MWS_W-1:0]  MWS_RST  = MWS_W'(16000);
  localparam logic [TRIM_W-1:0] TRIM_RST = TRIM_W'(32784);

  typedef logic [1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_HALF_TRACK = 2'd0;
  localparam cfg_idx_t CFG_RPM_SPEED  = 2'd1;
  localparam cfg_idx_t CFG_MAX_WHEEL  = 2'd2;
  localparam cfg_idx_t CFG_RIGHT_TRIM = 2'd3;

  typedef struct packed {
    logic [HTW_W-1:0]  htw;
    logic [RPS_W-1:0]  rps;
    logic [MWS_W-1:0]  mws;
    logic [TRIM_W-1:0] trim;
  } cfg_t;

  typedef struct packed {
    logic signed [WHEEL_W-1:0] wl;
    logic signed [WHEEL_W-1:0] wr;
    logic [MAG_W-1:0]          peak;
    logic                      scale;
  } mix_item_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_LOAD,
    B_DIV,
    B_DONE
  } back_state_t;

  function automatic logic [MAG_W-1:0] wheel_mag(input logic signed [WHEEL_W-1:0] w);
    logic [WHEEL_W-1:0] n;
    n = -w;
    return w[WHEEL_W-1] ? n[MAG_W-1:0] : w[MAG_W-1:0];
  endfunction

endpackage

[src/ddwm_front.sv]
module ddwm_front import ddwm_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  cfg_t                  cfg,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [TDATA_IN_W-1:0] in_tdata,
  input  logic                  in_tuser,
  output logic                  push_valid,
  input  logic                  push_ready,
  output mix_item_t             push_item
);

  function automatic logic signed [WHEEL_W-1:0] round18(input logic signed [PROD_W-1:0] v);
    logic [PROD_W-1:0]  mag;
    logic [PROD_W-1:0]  sum;
    logic [WHEEL_W-1:0] m;
    mag = v[PROD_W-1] ? -v : v;
    sum = mag + (PROD_W'(1) << 17);
    m   = {1'b0, sum[PROD_W-1:18]};
    return v[PROD_W-1] ? -m : m;
  endfunction

  function automatic logic signed [WHEEL_W-1:0] round15(input logic signed [TPROD_W-1:0] v);
    logic [TPROD_W-1:0]  mag;
    logic [TPROD_W-1:0]  sum;
    logic [WHEEL_W-1:0]  m;
    mag = v[TPROD_W-1] ? -v : v;
    sum = mag + (TPROD_W'(1) << 14);
    m   = {1'b0, sum[15 +: MAG_W]};
    return v[TPROD_W-1] ? -m : m;
  endfunction

  logic [5:0] v_r;
  logic       adv;

  logic signed [SPD_W-1:0]     lin, turn;
  logic signed [DELTA_W:0]     delta_full;
  logic signed [SPD_W-1:0]     lin1_r;
  logic signed [DELTA_W-1:0]   d1_r;
  logic signed [DELTA_W-1:0]   base2;
  logic signed [TRACK_W-1:0]   sl2_r, sr2_r;
  logic signed [PROD_W:0]      pl_full, pr_full;
  logic signed [PROD_W-1:0]    pl3_r, pr3_r;
  logic signed [WHEEL_W-1:0]   wl4_r, wr4_r, wl5_r, wr5_r, wl6_r, wr6_r;
  logic signed [TPROD_W:0]     tp_full;
  logic signed [TPROD_W-1:0]   tp5_r;
  logic                        trim1_r, trim2_r, trim3_r, trim4_r, trim5_r;
  logic [MAG_W-1:0]            ml, mr, peak;

  assign adv       = !v_r[5] || push_ready;
  assign in_tready = adv;

  assign lin        = in_tdata[SPD_W-1:0];
  assign turn       = in_tdata[2*SPD_W-1:SPD_W];
  assign delta_full = turn * $signed({1'b0, cfg.htw});
  assign base2      = {lin1_r, 16'h0000};
  assign pl_full    = sl2_r * $signed({1'b0, cfg.rps});
  assign pr_full    = sr2_r * $signed({1'b0, cfg.rps});
  assign tp_full    = wr4_r * $signed({1'b0, cfg.trim});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= {v_r[4:0], in_tvalid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      lin1_r  <= lin;
      d1_r    <= delta_full[DELTA_W-1:0];
      trim1_r <= in_tuser && (lin != '0);

      sl2_r   <= {base2[DELTA_W-1], base2} - {d1_r[DELTA_W-1], d1_r};
      sr2_r   <= {base2[DELTA_W-1], base2} + {d1_r[DELTA_W-1], d1_r};
      trim2_r <= trim1_r;

      pl3_r   <= pl_full[PROD_W-1:0];
      pr3_r   <= pr_full[PROD_W-1:0];
      trim3_r <= trim2_r;

      wl4_r   <= round18(pl3_r);
      wr4_r   <= round18(pr3_r);
      trim4_r <= trim3_r;

      tp5_r   <= tp_full[TPROD_W-1:0];
      wl5_r   <= wl4_r;
      wr5_r   <= wr4_r;
      trim5_r <= trim4_r;

      wl6_r   <= wl5_r;
      wr6_r   <= trim5_r ? round15(tp5_r) : wr5_r;
    end
  end

  assign ml   = wheel_mag(wl6_r);
  assign mr   = wheel_mag(wr6_r);
  assign peak = (ml > mr) ? ml : mr;

  assign push_valid      = v_r[5];
  assign push_item.wl    = wl6_r;
  assign push_item.wr    = wr6_r;
  assign push_item.peak  = peak;
  assign push_item.scale = peak > MAG_W'({cfg.mws, 8'h00});

endmodule

[src/ddwm_queue.sv]
module ddwm_queue import ddwm_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push_valid,
  output logic      push_ready,
  input  mix_item_t push_item,
  output logic      pop_valid,
  input  logic      pop,
  output mix_item_t pop_item
);

  mix_item_t  ent_r [2];
  logic       wptr_r, rptr_r;
  logic [1:0] cnt_r;
  logic       do_push;

  assign push_ready = (cnt_r != 2'd2);
  assign pop_valid  = (cnt_r != 2'd0);
  assign pop_item   = ent_r[rptr_r];
  assign do_push    = push_valid && push_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      if (do_push) wptr_r <= !wptr_r;
      if (pop)     rptr_r <= !rptr_r;
      case ({do_push, pop})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) ent_r[wptr_r] <= push_item;
  end

endmodule

[src/ddwm_back.sv]
module ddwm_back import ddwm_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic [MWS_W-1:0]       mws,
  input  logic                   pop_valid,
  output logic                   pop,
  input  mix_item_t              pop_item,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [TDATA_OUT_W-1:0] out_tdata,
  output logic                   out_tuser
);

  function automatic logic signed [OUT_W-1:0] sat(input logic neg, input logic [RND_W-1:0] m);
    logic [QUO_W-1:0] c;
    logic [OUT_W-1:0] p;
    c = (m > RND_W'(OUT_LIMIT)) ? OUT_LIMIT : m[QUO_W-1:0];
    p = {1'b0, c};
    return neg ? -p : p;
  endfunction

  back_state_t state_r, state_nxt;
  logic        slot_free, load_direct, load_div, capture;

  logic                    neg_l_r, neg_r_r;
  logic [MAG_W-1:0]        mag_l_r, mag_r_r, peak_r;
  logic [MAG_W-1:0]        rem_l_r, rem_r_r;
  logic [QUO_W-1:0]        lo_l_r, lo_r_r, q_l_r, q_r_r;
  logic [CNT_W-1:0]        cnt_r;
  logic [NUM_W-1:0]        num_l, num_r;
  logic [MAG_W:0]          trial_l, trial_r;
  logic                    ge_l, ge_r;
  logic [MAG_W:0]          sum_l, sum_r;
  logic signed [OUT_W-1:0] rt_r, lt_r;
  logic                    sc_r, ov_r;

  assign slot_free = !ov_r || out_tready;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      B_IDLE: if (pop_valid && pop_item.scale) state_nxt = B_LOAD;
      B_LOAD: state_nxt = B_DIV;
      B_DIV:  if (cnt_r == CNT_W'(QUO_W - 1)) state_nxt = B_DONE;
      B_DONE: if (slot_free) state_nxt = B_IDLE;
      default: state_nxt = B_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    pop         = 1'b0;
    load_direct = 1'b0;
    load_div    = 1'b0;
    capture     = 1'b0;
    case (state_r)
      B_IDLE: begin
        if (pop_valid && pop_item.scale) begin
          pop     = 1'b1;
          capture = 1'b1;
        end else if (pop_valid && slot_free) begin
          pop         = 1'b1;
          load_direct = 1'b1;
        end
      end
      B_DONE:  load_div = slot_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= B_IDLE;
    else        state_r <= state_nxt;
  end

  // dividend: |w| * limit + peak / 2, quotient fits the limit width
  assign num_l = mag_l_r * mws + NUM_W'(peak_r >> 1);
  assign num_r = mag_r_r * mws + NUM_W'(peak_r >> 1);

  assign trial_l = {rem_l_r, lo_l_r[QUO_W-1]};
  assign trial_r = {rem_r_r, lo_r_r[QUO_W-1]};
  assign ge_l    = trial_l >= {1'b0, peak_r};
  assign ge_r    = trial_r >= {1'b0, peak_r};

  // unscaled path: round off the 8 fraction bits
  assign sum_l = {1'b0, wheel_mag(pop_item.wl)} + (MAG_W + 1)'(128);
  assign sum_r = {1'b0, wheel_mag(pop_item.wr)} + (MAG_W + 1)'(128);

  always_ff @(posedge clk) begin
    case (state_r)
      B_IDLE: begin
        if (capture) begin
          neg_l_r <= pop_item.wl[WHEEL_W-1];
          neg_r_r <= pop_item.wr[WHEEL_W-1];
          mag_l_r <= wheel_mag(pop_item.wl);
          mag_r_r <= wheel_mag(pop_item.wr);
          peak_r  <= pop_item.peak;
        end
      end
      B_LOAD: begin
        rem_l_r <= num_l[NUM_W-1:QUO_W];
        rem_r_r <= num_r[NUM_W-1:QUO_W];
        lo_l_r  <= num_l[QUO_W-1:0];
        lo_r_r  <= num_r[QUO_W-1:0];
        cnt_r   <= '0;
      end
      B_DIV: begin
        rem_l_r <= ge_l ? MAG_W'(trial_l - {1'b0, peak_r}) : trial_l[MAG_W-1:0];
        rem_r_r <= ge_r ? MAG_W'(trial_r - {1'b0, peak_r}) : trial_r[MAG_W-1:0];
        lo_l_r  <= {lo_l_r[QUO_W-2:0], 1'b0};
        lo_r_r  <= {lo_r_r[QUO_W-2:0], 1'b0};
        q_l_r   <= {q_l_r[QUO_W-2:0], ge_l};
        q_r_r   <= {q_r_r[QUO_W-2:0], ge_r};
        cnt_r   <= cnt_r + CNT_W'(1);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (load_direct || load_div) begin
      ov_r <= 1'b1;
    end else if (out_tready) begin
      ov_r <= 1'b0;
    end
  end

  // left target leaves negated for mounting
  always_ff @(posedge clk) begin
    if (load_direct) begin
      rt_r <= sat(pop_item.wr[WHEEL_W-1], sum_r[MAG_W:8]);
      lt_r <= sat(!pop_item.wl[WHEEL_W-1], sum_l[MAG_W:8]);
      sc_r <= 1'b0;
    end else if (load_div) begin
      rt_r <= sat(neg_r_r, RND_W'(q_r_r));
      lt_r <= sat(!neg_l_r, RND_W'(q_l_r));
      sc_r <= 1'b1;
    end
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = {{(TDATA_OUT_W - 2*OUT_W){1'b0}}, lt_r, rt_r};
  assign out_tuser  = sc_r;

endmodule

[src/differential_drive_wheel_mixer.sv]
// An unscaled word passes the front pipeline registers, the queue and the output register;
// a scaled word also takes one 14-step divider pass for both wheels.
// Throughput: one word per cycle for unscaled words unless out_tready stalls; a scaled
// word holds the back end, and the front and 2-entry queue accept until the queue fills.
// Reset (rst_n low, synchronous): pipeline, queue and output emptied, registers to defaults.
module differential_drive_wheel_mixer import ddwm_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [TDATA_IN_W-1:0]  in_tdata,   // linear_speed [15:0], turn_rate [31:16]
  input  logic                   in_tuser,   // trim_enable
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [TDATA_OUT_W-1:0] out_tdata,  // right_target [14:0], left_target [29:15], zero
  output logic                   out_tuser,  // was_scaled
  input  logic                   cfg_we,
  input  cfg_idx_t               cfg_addr,
  input  logic [CFG_W-1:0]       cfg_wdata
);

  cfg_t      cfg_r;
  logic      push_valid, push_ready, pop_valid, pop;
  mix_item_t push_item, pop_item;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.htw  <= HTW_RST;
      cfg_r.rps  <= RPS_RST;
      cfg_r.mws  <= MWS_RST;
      cfg_r.trim <= TRIM_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_HALF_TRACK: cfg_r.htw  <= cfg_wdata[HTW_W-1:0];
        CFG_RPM_SPEED:  cfg_r.rps  <= cfg_wdata[RPS_W-1:0];
        CFG_MAX_WHEEL:  cfg_r.mws  <= cfg_wdata[MWS_W-1:0];
        CFG_RIGHT_TRIM: cfg_r.trim <= cfg_wdata[TRIM_W-1:0];
        default: ;
      endcase
    end
  end

  ddwm_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item)
  );

  ddwm_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop        (pop),
    .pop_item   (pop_item)
  );

  ddwm_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .mws        (cfg_r.mws),
    .pop_valid  (pop_valid),
    .pop        (pop),
    .pop_item   (pop_item),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule
